// ===== sv/u128_pkg.sv =====
package u128_pkg;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_MOD = 4'd4,
      OP_AND = 4'd5,
      OP_OR  = 4'd6,
      OP_XOR = 4'd7,
      OP_NOT = 4'd8,
      OP_SHL = 4'd9,
      OP_SHR = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_NEG  = 2'd2,
      ST_DIV0 = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [63:0] a_low;
      logic [63:0] a_high;
      logic [63:0] b_low;
      logic [63:0] b_high;
      logic [6:0]  shift_amount;
   } req_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ===== sv/uint128_checked_alu.sv =====
// Add, sub, logic and shift words go from S_RUN straight to S_DONE.
// Mul, div and mod (with a nonzero divisor) also pass through S_ITER, where one shared
// adder/subtractor runs one operand bit per cycle.
// One word is in flight at a time; req_ready is low while a word is being worked,
// and it rises again in the cycle after the result is taken.
// Synchronous active-high reset returns to idle and drops rsp_valid.
module uint128_checked_alu #(
   parameter int HALF_WIDTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  u128_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output u128_pkg::rsp_type  rsp_data
);

   localparam int DW = 2 * HALF_WIDTH;
   localparam int CW = $clog2(DW + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_ITER,
      S_DONE
   } state_type;

   state_type             state_ff;
   logic [3:0]            mode_ff;
   logic [6:0]            sh_ff;
   logic [DW-1:0]         a_ff;
   logic [DW-1:0]         b_ff;
   logic [DW-1:0]         acc_ff;
   logic [DW-1:0]         q_ff;
   logic                  ovf_ff;
   logic [CW-1:0]         cnt_ff;
   logic                  rsp_valid_ff;
   logic [DW-1:0]         res_ff;
   logic [1:0]            status_ff;

   // shared adder/subtractor
   logic [DW-1:0] op_x;
   logic [DW-1:0] op_y;
   logic          op_sub;
   logic [DW:0]   sum;

   assign sum = op_sub ? ({1'b0, op_x} - {1'b0, op_y}) : ({1'b0, op_x} + {1'b0, op_y});

   logic [DW-1:0] mul_sh;
   logic [DW-1:0] div_rr;
   logic          div_out;
   logic [CW-1:0] bit_idx;

   assign bit_idx = cnt_ff - CW'(1);
   assign mul_sh  = {acc_ff[DW-2:0], 1'b0};
   assign div_out = acc_ff[DW-1];
   assign div_rr  = {acc_ff[DW-2:0], a_ff[bit_idx[$clog2(DW)-1:0]]};

   always_comb begin
      op_x   = a_ff;
      op_y   = b_ff;
      op_sub = 1'b0;
      case (state_ff)
         S_ITER: begin
            if (mode_ff == u128_pkg::OP_MUL) begin
               op_x = mul_sh;
               op_y = a_ff;
            end else begin
               op_x   = div_rr;
               op_y   = b_ff;
               op_sub = 1'b1;
            end
         end
         default: begin
            op_sub = (mode_ff == u128_pkg::OP_SUB);
         end
      endcase
   end

   logic [DW-1:0] shl_v;
   logic [DW-1:0] shr_v;
   assign shl_v = (32'(sh_ff) >= DW) ? '0 : (a_ff << sh_ff);
   assign shr_v = (32'(sh_ff) >= DW) ? '0 : (a_ff >> sh_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.result_low  = 64'(res_ff[HALF_WIDTH-1:0]);
   assign rsp_data.result_high = 64'(res_ff[DW-1:HALF_WIDTH]);
   assign rsp_data.status      = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  mode_ff  <= req_data.mode;
                  sh_ff    <= req_data.shift_amount;
                  a_ff     <= {req_data.a_high[HALF_WIDTH-1:0],
                               req_data.a_low[HALF_WIDTH-1:0]};
                  b_ff     <= {req_data.b_high[HALF_WIDTH-1:0],
                               req_data.b_low[HALF_WIDTH-1:0]};
                  acc_ff   <= '0;
                  q_ff     <= '0;
                  ovf_ff   <= 1'b0;
                  cnt_ff   <= CW'(DW);
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               status_ff <= u128_pkg::ST_OK;
               res_ff    <= '0;
               state_ff  <= S_DONE;
               case (mode_ff)
                  u128_pkg::OP_ADD: begin
                     if (sum[DW]) status_ff <= u128_pkg::ST_OVF;
                     else res_ff <= sum[DW-1:0];
                  end
                  u128_pkg::OP_SUB: begin
                     if (sum[DW]) status_ff <= u128_pkg::ST_NEG;
                     else res_ff <= sum[DW-1:0];
                  end
                  u128_pkg::OP_MUL: state_ff <= S_ITER;
                  u128_pkg::OP_DIV, u128_pkg::OP_MOD: begin
                     if (b_ff == '0) status_ff <= u128_pkg::ST_DIV0;
                     else state_ff <= S_ITER;
                  end
                  u128_pkg::OP_AND: res_ff <= a_ff & b_ff;
                  u128_pkg::OP_OR:  res_ff <= a_ff | b_ff;
                  u128_pkg::OP_XOR: res_ff <= a_ff ^ b_ff;
                  u128_pkg::OP_NOT: res_ff <= ~a_ff;
                  u128_pkg::OP_SHL: res_ff <= shl_v;
                  u128_pkg::OP_SHR: res_ff <= shr_v;
                  default: res_ff <= '0;
               endcase
            end
            S_ITER: begin
               cnt_ff <= bit_idx;
               if (mode_ff == u128_pkg::OP_MUL) begin
                  if (b_ff[bit_idx[$clog2(DW)-1:0]]) begin
                     acc_ff <= sum[DW-1:0];
                     if (acc_ff[DW-1] || sum[DW]) ovf_ff <= 1'b1;
                  end else begin
                     acc_ff <= mul_sh;
                     if (acc_ff[DW-1]) ovf_ff <= 1'b1;
                  end
               end else begin
                  if (div_out || !sum[DW]) begin
                     acc_ff <= sum[DW-1:0];
                     q_ff   <= {q_ff[DW-2:0], 1'b1};
                  end else begin
                     acc_ff <= div_rr;
                     q_ff   <= {q_ff[DW-2:0], 1'b0};
                  end
               end
               if (bit_idx == '0) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff) begin
                  if (mode_ff == u128_pkg::OP_MUL) begin
                     status_ff <= ovf_ff ? u128_pkg::ST_OVF : u128_pkg::ST_OK;
                     res_ff    <= ovf_ff ? '0 : acc_ff;
                  end else if ((mode_ff == u128_pkg::OP_DIV) && cnt_ff == '0) begin
                     res_ff    <= q_ff;
                     status_ff <= u128_pkg::ST_OK;
                  end else if ((mode_ff == u128_pkg::OP_MOD) && cnt_ff == '0) begin
                     res_ff    <= acc_ff;
                     status_ff <= u128_pkg::ST_OK;
                  end
                  rsp_valid_ff <= 1'b1;
               end else if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== sv/u128_checker.sv =====
module u128_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input u128_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word dropped or changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while result pending");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != u128_pkg::ST_OK |->
      rsp_data.result_low == '0 && rsp_data.result_high == '0)
      else $error("flagged result not zero");

endmodule

bind uint128_checked_alu u128_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== verif/uint128_checked_alu_tb.sv =====
`timescale 1ns / 1ps

module uint128_checked_alu_tb;

   localparam int MAX_CYCLES = 2_000_000;
   localparam int RAND_WORDS = 850;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   u128_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   u128_pkg::rsp_type rsp_data;

   uint128_checked_alu dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   u128_pkg::rsp_type alu_expected[$];
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 20;
   int recv_idle_pct = 68;
   bit hold_req = 0;
   bit recv_hold = 0;
   bit stim_done = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("timeout at %0t", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic u128_pkg::rsp_type alu_predict(u128_pkg::req_type w);
      logic [127:0] a, b, r;
      logic [128:0] sum;
      logic [255:0] prod;
      u128_pkg::rsp_type o;
      a = {w.a_high, w.a_low};
      b = {w.b_high, w.b_low};
      r = '0;
      o.status = u128_pkg::ST_OK;
      case (w.mode)
         u128_pkg::OP_ADD: begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum[128]) o.status = u128_pkg::ST_OVF;
            else r = sum[127:0];
         end
         u128_pkg::OP_SUB: begin
            if (a < b) o.status = u128_pkg::ST_NEG;
            else r = a - b;
         end
         u128_pkg::OP_MUL: begin
            prod = {128'b0, a} * {128'b0, b};
            if (prod[255:128] != 0) o.status = u128_pkg::ST_OVF;
            else r = prod[127:0];
         end
         u128_pkg::OP_DIV, u128_pkg::OP_MOD: begin
            if (b == 0) o.status = u128_pkg::ST_DIV0;
            else r = (w.mode == u128_pkg::OP_DIV) ? a / b : a % b;
         end
         u128_pkg::OP_AND: r = a & b;
         u128_pkg::OP_OR:  r = a | b;
         u128_pkg::OP_XOR: r = a ^ b;
         u128_pkg::OP_NOT: r = ~a;
         u128_pkg::OP_SHL: r = a << w.shift_amount;
         u128_pkg::OP_SHR: r = a >> w.shift_amount;
         default: r = '0;
      endcase
      o.result_low = r[63:0];
      o.result_high = r[127:64];
      return o;
   endfunction

   // word driver: holds valid until accepted
   task automatic send_word(u128_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      alu_expected.push_back(alu_predict(w));
   endtask

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (alu_expected.size() == 0) begin
               $display("%0t: unexpected word got %h", $time, rsp_data);
               fail_count++;
            end else begin
               u128_pkg::rsp_type e;
               e = alu_expected.pop_front();
               if (e.result_low !== rsp_data.result_low)
                  $display("%0t: result_low exp %h got %h", $time,
                           e.result_low, rsp_data.result_low);
               if (e.result_high !== rsp_data.result_high)
                  $display("%0t: result_high exp %h got %h", $time,
                           e.result_high, rsp_data.result_high);
               if (e.status !== rsp_data.status)
                  $display("%0t: status exp %0d got %0d", $time,
                           e.status, rsp_data.status);
               if (e !== rsp_data) fail_count++;
            end
         end
      end
   end

   function automatic logic [63:0] rand_half();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return {32'b0, $urandom()};
         3: return 64'd1 << $urandom_range(63);
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   function automatic u128_pkg::req_type rand_word();
      u128_pkg::req_type w;
      w.mode = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                         : 4'($urandom_range(10));
      w.a_low = rand_half();
      w.a_high = rand_half();
      w.b_low = rand_half();
      w.b_high = rand_half();
      if (w.mode == u128_pkg::OP_MUL && $urandom_range(1)) begin
         w.a_high = '0;
         w.b_high = '0;
         if ($urandom_range(1)) w.a_low = {32'b0, w.a_low[31:0]};
      end
      if ((w.mode == u128_pkg::OP_DIV || w.mode == u128_pkg::OP_MOD) &&
          $urandom_range(3) == 0) begin
         w.b_high = '0;
         w.b_low = $urandom_range(1) ? 64'd0 : 64'($urandom_range(9));
      end
      if (w.mode == u128_pkg::OP_SUB && $urandom_range(1)) begin
         w.b_high = w.a_high;
         if ($urandom_range(1)) w.b_low = w.a_low;
      end
      w.shift_amount = 7'($urandom());
      return w;
   endfunction

   typedef struct {
      u128_pkg::req_type w;
      bit                has_exp;
      u128_pkg::rsp_type e;
   } stim_row;

   stim_row dir_table[$];
   localparam logic [63:0] ONES = '1;

   function automatic u128_pkg::req_type mk(u128_pkg::op_type m,
                                            logic [63:0] al, logic [63:0] ah,
                                            logic [63:0] bl, logic [63:0] bh,
                                            logic [6:0] sh);
      u128_pkg::req_type w;
      w.mode = m; w.a_low = al; w.a_high = ah; w.b_low = bl; w.b_high = bh;
      w.shift_amount = sh;
      return w;
   endfunction

   function automatic u128_pkg::rsp_type rs(logic [63:0] lo, logic [63:0] hi,
                                            u128_pkg::status_type s);
      u128_pkg::rsp_type r;
      r.result_low = lo; r.result_high = hi; r.status = s;
      return r;
   endfunction

   initial begin
      u128_pkg::req_type w;
      req_valid = 0;
      req_data = '0;
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      dir_table.push_back('{mk(u128_pkg::OP_ADD, ONES, ONES, 1, 0, 0), 1,
                            rs(0, 0, u128_pkg::ST_OVF)});
      dir_table.push_back('{mk(u128_pkg::OP_ADD, ONES, 0, 1, 0, 0), 1,
                            rs(0, 1, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_ADD, ONES, ONES, 0, 0, 5), 1,
                            rs(ONES, ONES, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_SUB, 0, 0, 1, 0, 0), 1,
                            rs(0, 0, u128_pkg::ST_NEG)});
      dir_table.push_back('{mk(u128_pkg::OP_SUB, 0, 1, 1, 0, 0), 1,
                            rs(ONES, 0, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_SUB, ONES, ONES, ONES, ONES, 0), 1,
                            rs(0, 0, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_MUL, ONES, ONES, ONES, ONES, 0), 1,
                            rs(0, 0, u128_pkg::ST_OVF)});
      dir_table.push_back('{mk(u128_pkg::OP_MUL, 0, 1, 0, 1, 0), 1,
                            rs(0, 0, u128_pkg::ST_OVF)});
      dir_table.push_back('{mk(u128_pkg::OP_MUL, ONES, 0, ONES, 0, 0), 0, '0});
      dir_table.push_back('{mk(u128_pkg::OP_MUL, ONES, ONES, 1, 0, 0), 1,
                            rs(ONES, ONES, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_DIV, 5, 5, 0, 0, 0), 1,
                            rs(0, 0, u128_pkg::ST_DIV0)});
      dir_table.push_back('{mk(u128_pkg::OP_MOD, 5, 5, 0, 0, 0), 1,
                            rs(0, 0, u128_pkg::ST_DIV0)});
      dir_table.push_back('{mk(u128_pkg::OP_DIV, ONES, ONES, 1, 0, 0), 1,
                            rs(ONES, ONES, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_MOD, ONES, ONES, 0, 1, 0), 1,
                            rs(ONES, 0, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_DIV, ONES, ONES, ONES, ONES, 0), 1,
                            rs(1, 0, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_AND, ONES, 0, 64'h0f0f, ONES, 0), 0, '0});
      dir_table.push_back('{mk(u128_pkg::OP_OR, 0, 64'h1234, ONES, 0, 0), 0, '0});
      dir_table.push_back('{mk(u128_pkg::OP_XOR, ONES, ONES, ONES, 0, 0), 1,
                            rs(0, ONES, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_NOT, 0, ONES, ONES, ONES, 7'h7f), 1,
                            rs(ONES, 0, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_SHL, 1, 0, 0, 0, 127), 1,
                            rs(0, 64'h8000000000000000, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_SHL, ONES, ONES, 0, 0, 64), 1,
                            rs(0, ONES, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_SHR, ONES, ONES, 0, 0, 127), 1,
                            rs(1, 0, u128_pkg::ST_OK)});
      dir_table.push_back('{mk(u128_pkg::OP_SHR, ONES, 64'h5, 0, 0, 0), 1,
                            rs(ONES, 5, u128_pkg::ST_OK)});
      w = mk(u128_pkg::OP_ADD, ONES, ONES, ONES, ONES, 0);
      w.mode = 4'd15;
      dir_table.push_back('{w, 1, rs(0, 0, u128_pkg::ST_OK)});
      w.mode = 4'd11;
      dir_table.push_back('{w, 1, rs(0, 0, u128_pkg::ST_OK)});

      foreach (dir_table[i]) begin
         if (dir_table[i].has_exp && alu_predict(dir_table[i].w) !== dir_table[i].e) begin
            $display("%0t: table row %0d exp %h got %h", $time, i,
                     dir_table[i].e, alu_predict(dir_table[i].w));
            fail_count++;
         end
         send_word(dir_table[i].w);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 68 : 0;
         recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 20 : 0;
         for (int n = 0; n < RAND_WORDS / 3; n++) begin
            if (phase == 2 && n == 20) hold_req = 1;
            send_word(rand_word());
         end
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // long receiver hold-off while words keep coming
   initial begin
      int held;
      wait (hold_req);
      recv_hold = 1;
      held = 0;
      while (held < 600) begin
         @(posedge clock);
         held++;
      end
      recv_hold = 0;
   end

   initial begin
      wait (stim_done);
      while (alu_expected.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
